// ===== hdl/assert_macros.svh =====
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define ASSERT_SAME(lbl, pre, post, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== hdl/tqg_pkg.sv =====
package tqg_pkg;

  localparam int GLYPH_HEIGHT = 24;
  localparam int GLYPH_COUNT  = 256;
  localparam int GLYPH_IDX_W  = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

  localparam int CODE_W    = 8;
  localparam int TEXEL_W   = 10;
  localparam int GWIDTH_W  = 11;
  localparam int METRIC_W  = 2 * TEXEL_W + GWIDTH_W;
  localparam int TEX_W     = 17;
  localparam int WLEFT_W   = 17;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_CHAR  = 2'd2;

  localparam logic [CODE_W-1:0] CODE_END   = 8'd0;
  localparam logic [CODE_W-1:0] CODE_SPACE = 8'd32;

  localparam logic [11:0] SPACE_GAP = 12'd5;
  localparam logic [11:0] OTHER_GAP = 12'd2;

  localparam logic [3:0] LG_MIN   = 4'd5;
  localparam logic [3:0] LG_MAX   = 4'd10;
  localparam logic [3:0] LG_RESET = 4'd5;
  localparam logic [TEX_W-1:0] TEX_MAX = 17'h1ffff;

  // unscaled quad handed from the string logic to the vertex sequencer
  typedef struct packed {
    logic [15:0]         x0;
    logic [15:0]         x1;
    logic [15:0]         y0;
    logic [15:0]         y1;
    logic [GWIDTH_W-1:0] u0;
    logic [GWIDTH_W-1:0] u1;
    logic [GWIDTH_W-1:0] v0;
    logic [GWIDTH_W-1:0] v1;
    logic [31:0]         colour;
  } quad_t;

  // texel to 16-bit fraction of the texture side, saturated
  function automatic logic [TEX_W-1:0] tex_scale(input logic [GWIDTH_W-1:0] texel,
                                                 input logic [3:0] lg);
    logic [3:0]  lg_c;
    logic [3:0]  sh;
    logic [21:0] wide;
    lg_c = lg;
    if (lg_c < LG_MIN) lg_c = LG_MIN;
    if (lg_c > LG_MAX) lg_c = LG_MAX;
    sh   = 4'd15 - lg_c + 4'd1;
    wide = {11'd0, texel} << sh;
    return (wide > {5'd0, TEX_MAX}) ? TEX_MAX : wide[TEX_W-1:0];
  endfunction

endpackage

// ===== hdl/tqg_glyph_table.sv =====
module tqg_glyph_table
  import tqg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [CODE_W-1:0]   wr_code,
  input  logic [METRIC_W-1:0] wr_data,
  input  logic                rd_en,
  input  logic [CODE_W-1:0]   rd_code,
  output logic [METRIC_W-1:0] rd_data
);

  logic [METRIC_W-1:0] mem [GLYPH_COUNT];
  logic [GLYPH_COUNT-1:0] vld_r;
  logic [METRIC_W-1:0] data_r;
  logic                hit_r;
  logic                wr_in_range;
  logic                rd_in_range;

  assign wr_in_range = {1'b0, wr_code} < 9'(GLYPH_COUNT);
  assign rd_in_range = {1'b0, rd_code} < 9'(GLYPH_COUNT);

  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      mem[wr_code[GLYPH_IDX_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      data_r <= mem[rd_code[GLYPH_IDX_W-1:0]];
    end
  end

  // entries never loaded read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (wr_en && wr_in_range) begin
        vld_r[wr_code[GLYPH_IDX_W-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        hit_r <= rd_in_range && vld_r[rd_code[GLYPH_IDX_W-1:0]];
      end
    end
  end

  assign rd_data = hit_r ? data_r : '0;

endmodule

// ===== hdl/tqg_quad_emitter.sv =====
module tqg_quad_emitter
  import tqg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  quad_t                   quad,
  input  logic [3:0]              tex_lg,
  output logic                    free,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [15:0]      out_vert_x,
  output logic signed [15:0]      out_vert_y,
  output logic [TEX_W-1:0]        out_tex_u,
  output logic [TEX_W-1:0]        out_tex_v,
  output logic [31:0]             out_vert_colour,
  output logic                    out_end_of_strip,
  output logic                    out_last
);

  logic              valid_r;
  logic [1:0]        cnt_r;
  logic [15:0]       x0_r, x1_r, y0_r, y1_r;
  logic [TEX_W-1:0]  u0_r, u1_r, v0_r, v1_r;
  logic [31:0]       colour_r;
  logic              fire;
  logic              done;

  assign fire = valid_r && !out_stall;
  assign done = fire && (cnt_r == 2'd3);
  assign free = !valid_r || done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= 2'd0;
    end else if (load) begin
      valid_r <= 1'b1;
      cnt_r   <= 2'd0;
    end else if (done) begin
      valid_r <= 1'b0;
    end else if (fire) begin
      cnt_r <= cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x0_r     <= quad.x0;
      x1_r     <= quad.x1;
      y0_r     <= quad.y0;
      y1_r     <= quad.y1;
      u0_r     <= tex_scale(quad.u0, tex_lg);
      u1_r     <= tex_scale(quad.u1, tex_lg);
      v0_r     <= tex_scale(quad.v0, tex_lg);
      v1_r     <= tex_scale(quad.v1, tex_lg);
      colour_r <= quad.colour;
    end
  end

  // strip order: top-left, top-right, bottom-left, bottom-right
  assign out_valid        = valid_r;
  assign out_vert_x       = signed'(cnt_r[0] ? x1_r : x0_r);
  assign out_vert_y       = signed'(cnt_r[1] ? y1_r : y0_r);
  assign out_tex_u        = cnt_r[0] ? u1_r : u0_r;
  assign out_tex_v        = cnt_r[1] ? v1_r : v0_r;
  assign out_vert_colour  = colour_r;
  assign out_end_of_strip = (cnt_r == 2'd3);
  assign out_last         = (cnt_r == 2'd3);

endmodule

// ===== hdl/text_quad_generator.sv =====
// Text quad generator: glyph loads, string starts and characters enter a holding
// stage, one beat per cycle while in_stall is low, as the glyph table is read; the
// stage then updates the pen and width budget. A drawn character gives four vertex
// beats, one per cycle while out_stall is low, on the single result port; loads,
// starts, code 0 and glyphs of width zero draw nothing and may pass while the
// previous quad is still being sent. A beat is registered in the holding stage, then
// in the emitter, before its first vertex. The glyph table needs no clearing pass:
// per-entry valid bits cleared by reset make unloaded entries read as zero.
`include "assert_macros.svh"
module text_quad_generator
  import tqg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [3:0]           cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_kind,
  input  logic [CODE_W-1:0]    in_code,
  input  logic [TEXEL_W-1:0]   in_glyph_u,
  input  logic [TEXEL_W-1:0]   in_glyph_v,
  input  logic [GWIDTH_W-1:0]  in_glyph_width,
  input  logic signed [15:0]   in_pos_x,
  input  logic signed [15:0]   in_pos_y,
  input  logic [14:0]          in_max_width,
  input  logic [31:0]          in_colour,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   out_vert_x,
  output logic signed [15:0]   out_vert_y,
  output logic [TEX_W-1:0]     out_tex_u,
  output logic [TEX_W-1:0]     out_tex_v,
  output logic [31:0]          out_vert_colour,
  output logic                 out_end_of_strip,
  output logic                 out_last
);

  logic [3:0]                tex_lg_r;
  logic                      in_accept;

  logic                      s1_valid_r;
  logic [1:0]                s1_kind_r;
  logic [CODE_W-1:0]         s1_code_r;
  logic [15:0]               s1_pos_x_r;
  logic [15:0]               s1_pos_y_r;
  logic [14:0]               s1_max_width_r;
  logic [31:0]               s1_colour_r;
  logic [METRIC_W-1:0]       metric;
  logic                      s1_adv;

  logic [15:0]               pen_x_r, pen_x_nxt;
  logic [15:0]               pen_y_r;
  logic signed [WLEFT_W-1:0] wl_r, wl_nxt;
  logic [31:0]               str_colour_r;
  logic                      str_active_r;

  logic [TEXEL_W-1:0]        g_u, g_v;
  logic [GWIDTH_W-1:0]       g_w, cw;
  logic [11:0]               adv;
  logic                      is_char;
  logic                      emits;
  logic                      em_free;
  logic                      em_load;
  quad_t                     quad;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_lg_r <= LG_RESET;
    end else if (cfg_wr_en) begin
      tex_lg_r <= cfg_wr_data;
    end
  end

  // glyph loads write the table at the input beat, so any later character sees them
  tqg_glyph_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_accept && (in_kind == KIND_LOAD)),
    .wr_code (in_code),
    .wr_data ({in_glyph_width, in_glyph_v, in_glyph_u}),
    .rd_en   (in_accept),
    .rd_code (in_code),
    .rd_data (metric)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind_r      <= in_kind;
      s1_code_r      <= in_code;
      s1_pos_x_r     <= unsigned'(in_pos_x);
      s1_pos_y_r     <= unsigned'(in_pos_y);
      s1_max_width_r <= in_max_width;
      s1_colour_r    <= in_colour;
    end
  end

  assign g_u = metric[TEXEL_W-1:0];
  assign g_v = metric[2*TEXEL_W-1:TEXEL_W];
  assign g_w = metric[METRIC_W-1:2*TEXEL_W];

  // budget is never negative while a string is active
  assign cw  = (signed'({6'd0, g_w}) > wl_r) ? wl_r[GWIDTH_W-1:0] : g_w;
  assign adv = {1'b0, cw} + ((s1_code_r == CODE_SPACE) ? SPACE_GAP : OTHER_GAP);
  assign pen_x_nxt = pen_x_r + {4'd0, adv};
  assign wl_nxt    = wl_r - signed'({5'd0, adv});

  assign is_char = (s1_kind_r == KIND_CHAR) && str_active_r && (s1_code_r != CODE_END);
  assign emits   = is_char && (g_w != '0);
  assign s1_adv  = s1_valid_r && (!emits || em_free);
  assign em_load = s1_adv && emits;

  assign quad.x0     = pen_x_r;
  assign quad.x1     = pen_x_r + {5'd0, cw};
  assign quad.y0     = pen_y_r;
  assign quad.y1     = pen_y_r + 16'(GLYPH_HEIGHT);
  assign quad.u0     = {1'b0, g_u};
  assign quad.u1     = {1'b0, g_u} + cw;
  assign quad.v0     = {1'b0, g_v};
  assign quad.v1     = {1'b0, g_v} + GWIDTH_W'(GLYPH_HEIGHT);
  assign quad.colour = str_colour_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r      <= '0;
      pen_y_r      <= '0;
      wl_r         <= '0;
      str_colour_r <= '0;
      str_active_r <= 1'b0;
    end else if (s1_adv) begin
      case (s1_kind_r)
        KIND_START: begin
          pen_x_r      <= s1_pos_x_r;
          pen_y_r      <= s1_pos_y_r;
          wl_r         <= signed'({2'd0, s1_max_width_r});
          str_colour_r <= s1_colour_r;
          str_active_r <= 1'b1;
        end
        KIND_CHAR: begin
          if (str_active_r) begin
            if (s1_code_r == CODE_END) begin
              str_active_r <= 1'b0;
            end else begin
              pen_x_r      <= pen_x_nxt;
              wl_r         <= wl_nxt;
              str_active_r <= (wl_nxt > 0);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  tqg_quad_emitter u_emitter (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (em_load),
    .quad             (quad),
    .tex_lg           (tex_lg_r),
    .free             (em_free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_vert_x       (out_vert_x),
    .out_vert_y       (out_vert_y),
    .out_tex_u        (out_tex_u),
    .out_tex_v        (out_tex_v),
    .out_vert_colour  (out_vert_colour),
    .out_end_of_strip (out_end_of_strip),
    .out_last         (out_last)
  );

  `ASSERT_SAME(a_load_when_free, em_load, em_free, "quad loaded while vertices pending")
  `ASSERT_SAME(a_draw_needs_string, em_load, str_active_r, "quad drawn with no active string")
  `ASSERT_NEXT(a_quad_continues, out_valid && !out_stall && !out_last, out_valid,
               "quad cut short before its fourth vertex")

endmodule
